// ===== hdl/rlgd_pkg.sv =====
// Shared types and codes for the radiosonde level group decoder.
package rlgd_pkg;

  // Default depth of the queue between the token front end and the back end
  localparam int QUEUE_DEPTH_DEF = 4;

  // Width of the value carried by a queued operation (largest is the station number)
  localparam int VAL_W = 17;
  localparam int SPD_W = 7;

  // Operations the front end hands to the back end
  localparam logic [1:0] OP_STATION = 2'd0;
  localparam logic [1:0] OP_LEVEL   = 2'd1;
  localparam logic [1:0] OP_TEMP    = 2'd2;
  localparam logic [1:0] OP_WIND    = 2'd3;

  // One queued operation
  //   OP_STATION: val = station number
  //   OP_LEVEL:   val = level height in metres
  //   OP_TEMP:    val = raw three digit temperature group value
  //   OP_WIND:    val = wind direction ddd, spd = wind speed ff
  typedef struct packed {
    logic [1:0]       kind;
    logic [VAL_W-1:0] val;
    logic [SPD_W-1:0] spd;
  } rlgd_op_t;

endpackage

// ===== hdl/rlgd_front.sv =====
// Token front end: message position tracking, digit decode and op generation.
module rlgd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  logic [1:0]         header_kind,
  input  logic [19:0]        chars,        // char_one in [3:0] up to char_five in [19:16]
  input  logic [2:0]         token_length,
  input  logic               has_double_slash,
  input  logic               last_in_message,
  input  logic               q_full,
  output logic               push,
  output rlgd_pkg::rlgd_op_t op
);
  import rlgd_pkg::*;

  // Position within the message
  localparam logic [1:0] POS_HEADER  = 2'd0;
  localparam logic [1:0] POS_SKIP    = 2'd1;
  localparam logic [1:0] POS_STATION = 2'd2;
  localparam logic [1:0] POS_GROUPS  = 2'd3;

  // Group within a triplet
  localparam logic [1:0] SLOT_LEVEL = 2'd0;
  localparam logic [1:0] SLOT_TEMP  = 2'd1;
  localparam logic [1:0] SLOT_WIND  = 2'd2;

  // Header kinds / message modes
  localparam logic [1:0] KIND_TTAA  = 2'd0;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Standard level codes
  localparam logic [6:0] LC_SURFACE = 7'd0;
  localparam logic [6:0] LC_925     = 7'd92;
  localparam logic [6:0] LC_850     = 7'd85;
  localparam logic [6:0] LC_700     = 7'd70;
  localparam logic [6:0] LC_500     = 7'd50;
  localparam logic [6:0] LC_400     = 7'd40;
  localparam logic [6:0] LC_300     = 7'd30;
  localparam logic [6:0] LC_250     = 7'd25;
  localparam logic [6:0] LC_200     = 7'd20;
  localparam logic [6:0] LC_150     = 7'd15;
  localparam logic [6:0] LC_100     = 7'd10;

  // Decimal value of characters first..first+count-1 within the token length;
  // zero if any of them is not a digit or none lies within the token
  function automatic logic [VAL_W-1:0] read_num(input logic [19:0] c, input int first,
                                                input int count, input logic [2:0] len);
    logic [VAL_W-1:0] v;
    logic             bad;
    logic [3:0]       ch;
    v   = '0;
    bad = 1'b0;
    for (int i = 0; i < 5; i++) begin
      ch = c[4*i +: 4];
      if (i >= first && i < first + count && i < int'(len)) begin
        if (ch > 4'd9) begin
          bad = 1'b1;
        end else begin
          v = VAL_W'(v * VAL_W'(10) + VAL_W'(ch));
        end
      end
    end
    return bad ? '0 : v;
  endfunction

  logic [1:0]       pos_r, pos_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic             usable_r, usable_nxt;

  logic             fire;
  logic             full_len;
  logic [VAL_W-1:0] station;
  logic [6:0]       code;
  logic [9:0]       hgt;
  logic [9:0]       three_dig;
  logic [SPD_W-1:0] spd;
  logic [14:0]      hgt_x10;
  logic [14:0]      metres;
  logic             lvl;
  logic             wind_ok;

  assign tok_ready = !q_full;
  assign fire      = tok_valid && tok_ready;
  assign full_len  = (token_length >= 3'd5);

  // Field decode and height table
  always_comb begin
    station   = read_num(chars, 0, 5, token_length);
    code      = 7'(read_num(chars, 0, 2, token_length));
    hgt       = 10'(read_num(chars, 2, 3, token_length));
    three_dig = 10'(read_num(chars, 0, 3, token_length));
    spd       = SPD_W'(read_num(chars, 3, 2, token_length));
    hgt_x10   = 15'({hgt, 3'b000}) + 15'({hgt, 1'b0});
    lvl       = 1'b1;
    metres    = '0;
    case (code)
      LC_SURFACE, LC_925: metres = 15'(hgt);
      LC_850: metres = 15'(hgt) + 15'd1000;
      LC_700: metres = 15'(hgt) + 15'd3000;
      LC_500, LC_400, LC_300: metres = hgt_x10;
      LC_250, LC_200, LC_150, LC_100: metres = hgt_x10 + 15'd10000;
      default: lvl = 1'b0;
    endcase
  end

  assign wind_ok = (mode_r == KIND_TTAA) && usable_r && full_len && !has_double_slash;

  // Message sequencing and op generation
  always_comb begin
    pos_nxt    = pos_r;
    slot_nxt   = slot_r;
    mode_nxt   = mode_r;
    usable_nxt = usable_r;
    push       = 1'b0;
    op.kind    = OP_STATION;
    op.val     = station;
    op.spd     = spd;
    if (fire) begin
      case (pos_r)
        POS_HEADER: begin
          if (header_kind != KIND_OTHER) begin
            mode_nxt = header_kind;
          end
          pos_nxt = POS_SKIP;
        end
        POS_SKIP: begin
          pos_nxt = POS_STATION;
        end
        POS_STATION: begin
          push     = 1'b1;
          pos_nxt  = POS_GROUPS;
          slot_nxt = SLOT_LEVEL;
        end
        default: begin
          case (slot_r)
            SLOT_LEVEL: begin
              usable_nxt = lvl && full_len;
              push       = lvl;
              op.kind    = OP_LEVEL;
              op.val     = VAL_W'(metres);
              slot_nxt   = SLOT_TEMP;
            end
            SLOT_TEMP: begin
              if (!full_len) begin
                usable_nxt = 1'b0;
              end
              push     = 1'b1;
              op.kind  = OP_TEMP;
              op.val   = VAL_W'(three_dig);
              slot_nxt = SLOT_WIND;
            end
            default: begin
              push       = wind_ok;
              op.kind    = OP_WIND;
              op.val     = VAL_W'(three_dig);
              usable_nxt = 1'b0;
              slot_nxt   = SLOT_LEVEL;
            end
          endcase
        end
      endcase
      if (last_in_message) begin
        pos_nxt  = POS_HEADER;
        slot_nxt = SLOT_LEVEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HEADER;
      slot_r   <= SLOT_LEVEL;
      mode_r   <= KIND_OTHER;
      usable_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      slot_r   <= slot_nxt;
      mode_r   <= mode_nxt;
      usable_r <= usable_nxt;
    end
  end

endmodule

// ===== hdl/rlgd_queue.sv =====
// Small FIFO of decoded ops between the front end and the back end.
module rlgd_queue #(
  parameter int DEPTH = rlgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rlgd_pkg::rlgd_op_t wr_op,
  input  logic               pop,
  output rlgd_pkg::rlgd_op_t rd_op,
  output logic               not_empty,
  output logic               full
);
  import rlgd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlgd_op_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign rd_op     = slots[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));

  // Occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = CNT_W'(count_r + 1'b1);
      2'b01:   count_nxt = CNT_W'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/rlgd_back.sv =====
// Back end: unit conversion pipeline, held message values and result register.
module rlgd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rlgd_pkg::rlgd_op_t q_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_data
);
  import rlgd_pkg::*;

  // ceil(2^34 / 12500): feet/1000 = floor((41*m + 6250) / 12500), exact for m < 20000
  localparam logic [20:0] RECIP     = 21'd1374390;
  localparam int          RECIP_SHR = 34;

  logic             en;

  logic             a_valid_r;
  rlgd_op_t         a_op_r;

  logic             b_valid_r;
  rlgd_op_t         b_op_r;
  logic [19:0]      b_prod_r;
  logic [19:0]      b_prod_nxt;

  logic             c_valid_r;
  logic [1:0]       c_kind_r;
  logic [16:0]      c_val_r;
  logic [7:0]       c_temp_r;
  logic [9:0]       c_dir_r;
  logic [7:0]       c_spd_r;

  logic [40:0]      lvl_prod;
  logic [6:0]       mag;
  logic [7:0]       temp_nxt;
  logic [7:0]       quot5;
  logic [9:0]       five_q;
  logic [9:0]       rem5;
  logic             hundred;
  logic [9:0]       dir_nxt;
  logic [7:0]       spd_nxt;
  logic [16:0]      c_val_nxt;

  logic [16:0]      station_r;
  logic [16:0]      alt_r;
  logic [7:0]       temp_r;

  logic             out_valid_r;
  logic [63:0]      out_data_r;

  // Whole pipe moves when the result register can take a word
  assign en        = !out_valid_r || out_ready;
  assign pop       = en && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage A to B: constant multiply (41m + 6250 for heights, x205 for /10 and /5)
  always_comb begin
    if (a_op_r.kind == OP_LEVEL) begin
      b_prod_nxt = 20'(a_op_r.val[14:0]) * 20'd41 + 20'd6250;
    end else begin
      b_prod_nxt = 20'(a_op_r.val[9:0]) * 20'd205;
    end
  end

  // Stage B to C: reciprocal multiply, temperature sign, hundred-knot correction
  always_comb begin
    lvl_prod = 41'(b_prod_r) * 41'(RECIP);
    mag      = b_prod_r[17:11];
    temp_nxt = b_op_r.val[0] ? 8'(8'd0 - {1'b0, mag}) : {1'b0, mag};
    quot5    = b_prod_r[17:10];
    five_q   = 10'({quot5, 2'b00}) + 10'(quot5);
    rem5     = b_op_r.val[9:0] - five_q;
    hundred  = (rem5 == 10'd1);
    dir_nxt  = hundred ? 10'(b_op_r.val[9:0] - 10'd1) : b_op_r.val[9:0];
    spd_nxt  = hundred ? 8'(8'(b_op_r.spd) + 8'd100) : 8'(b_op_r.spd);
    if (b_op_r.kind == OP_LEVEL) begin
      c_val_nxt = 17'(lvl_prod[40:RECIP_SHR]);
    end else begin
      c_val_nxt = b_op_r.val;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r   <= q_op;
      b_op_r   <= a_op_r;
      b_prod_r <= b_prod_nxt;
      c_kind_r <= b_op_r.kind;
      c_val_r  <= c_val_nxt;
      c_temp_r <= temp_nxt;
      c_dir_r  <= dir_nxt;
      c_spd_r  <= spd_nxt;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= q_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Stage C: update held values or form a result word
  always_ff @(posedge clk) begin
    if (en && c_valid_r) begin
      case (c_kind_r)
        OP_STATION: station_r <= c_val_r;
        OP_LEVEL:   alt_r     <= 17'(c_val_r[6:0]) * 17'd1000;
        OP_TEMP:    temp_r    <= c_temp_r;
        default: begin
          out_data_r <= {4'b0000, temp_r, c_spd_r, c_dir_r, alt_r, station_r};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && c_valid_r && c_kind_r == OP_WIND) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/radiosonde_level_group_decoder_core.sv =====
// Top level of the radiosonde TTAA level group decoder.
//
// Input channel (in_*): one message token per word. in_tuser carries the
// header kind, in_tdata the five character digit codes, the token length and
// the double-slash flag; in_tlast marks the final token of a message.
// Output channel (out_*): one word per usable TTAA level triplet, carrying
// station number, altitude in feet (rounded to thousands), wind direction,
// wind speed and temperature.
// Throughput: one token per cycle while the op queue has room. The front end
// updates message position in the accept cycle and queues an op; the back
// end runs a three stage constant multiply pipeline (height to feet), stages
// A, B and C, before the result register that drives out_tvalid.
// Reset clears message position, triplet slot, the queue and the pipeline,
// and leaves no message mode selected.
// When the receiver stalls, the result word holds, the back end pipeline
// freezes, and tokens keep entering until the op queue (QUEUE_DEPTH words)
// is full; in_tready then drops until the receiver takes the word.
module radiosonde_level_group_decoder_core #(
  parameter int QUEUE_DEPTH = rlgd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] char_one, [7:4] char_two, [11:8] char_three, [15:12] char_four,
  // [19:16] char_five, [22:20] token_length, [23] has_double_slash
  input  logic [23:0] in_tdata,
  // [1:0] header_kind
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [16:0] station_id, [33:17] altitude_ft, [43:34] wind_direction,
  // [51:44] wind_speed, [59:52] temperature, [63:60] zero
  output logic [63:0] out_tdata
);
  import rlgd_pkg::*;

  logic     push;
  rlgd_op_t push_op;
  logic     pop;
  rlgd_op_t head_op;
  logic     q_not_empty;
  logic     q_full;

  rlgd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (in_tvalid),
    .tok_ready        (in_tready),
    .header_kind      (in_tuser),
    .chars            (in_tdata[19:0]),
    .token_length     (in_tdata[22:20]),
    .has_double_slash (in_tdata[23]),
    .last_in_message  (in_tlast),
    .q_full           (q_full),
    .push             (push),
    .op               (push_op)
  );

  rlgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_op     (push_op),
    .pop       (pop),
    .rd_op     (head_op),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rlgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_op      (head_op),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
